FILE: design/source_token_lexer_macros.svh
// Assertion macros used by the lexer scanner (stl_back).
`ifndef SOURCE_TOKEN_LEXER_MACROS_SVH
`define SOURCE_TOKEN_LEXER_MACROS_SVH
`ifndef SYNTHESIS
`define STL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define STL_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define STL_ASSERT(label, clk, rst, prop, msg)
`define STL_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: design/stl_pkg.sv
package stl_pkg;

   localparam int KeywordBytesDefault = 8;
   localparam int LengthBitsDefault   = 16;
   localparam int LineBitsDefault     = 20;
   localparam int ColumnBits          = 16;
   localparam int KindBits            = 6;
   localparam int ModeBits            = 5;

   // Scanner modes.
   localparam logic [ModeBits-1:0] M_IDLE    = 5'd0;
   localparam logic [ModeBits-1:0] M_IDENT   = 5'd1;
   localparam logic [ModeBits-1:0] M_ZERO    = 5'd2;
   localparam logic [ModeBits-1:0] M_INT     = 5'd3;
   localparam logic [ModeBits-1:0] M_FRAC    = 5'd4;
   localparam logic [ModeBits-1:0] M_STR     = 5'd5;
   localparam logic [ModeBits-1:0] M_STRBAD  = 5'd6;
   localparam logic [ModeBits-1:0] M_SLASH   = 5'd7;
   localparam logic [ModeBits-1:0] M_COMMENT = 5'd8;
   localparam logic [ModeBits-1:0] M_PLUS    = 5'd9;
   localparam logic [ModeBits-1:0] M_MINUS   = 5'd10;
   localparam logic [ModeBits-1:0] M_STAR    = 5'd11;
   localparam logic [ModeBits-1:0] M_EQ      = 5'd12;
   localparam logic [ModeBits-1:0] M_BANG    = 5'd13;
   localparam logic [ModeBits-1:0] M_LT      = 5'd14;
   localparam logic [ModeBits-1:0] M_LT2     = 5'd15;
   localparam logic [ModeBits-1:0] M_GT      = 5'd16;
   localparam logic [ModeBits-1:0] M_GT2     = 5'd17;
   localparam logic [ModeBits-1:0] M_AMP     = 5'd18;
   localparam logic [ModeBits-1:0] M_AMP2    = 5'd19;
   localparam logic [ModeBits-1:0] M_BAR     = 5'd20;
   localparam logic [ModeBits-1:0] M_BAR2    = 5'd21;
   localparam logic [ModeBits-1:0] M_HASH    = 5'd22;
   localparam logic [ModeBits-1:0] M_DIRECT  = 5'd23;

   // Token kinds.
   localparam logic [KindBits-1:0] K_ERROR  = 6'd0;
   localparam logic [KindBits-1:0] K_IDENT  = 6'd1;
   localparam logic [KindBits-1:0] K_NUMBER = 6'd2;
   localparam logic [KindBits-1:0] K_STRING = 6'd3;
   localparam logic [KindBits-1:0] K_ASSIGN = 6'd24;
   localparam logic [KindBits-1:0] K_PLUS   = 6'd25;
   localparam logic [KindBits-1:0] K_PLUSEQ = 6'd26;
   localparam logic [KindBits-1:0] K_MINUS  = 6'd27;
   localparam logic [KindBits-1:0] K_MINEQ  = 6'd28;
   localparam logic [KindBits-1:0] K_STAR   = 6'd29;
   localparam logic [KindBits-1:0] K_STAREQ = 6'd30;
   localparam logic [KindBits-1:0] K_SLASH  = 6'd31;
   localparam logic [KindBits-1:0] K_SLASHEQ = 6'd32;
   localparam logic [KindBits-1:0] K_SHL    = 6'd33;
   localparam logic [KindBits-1:0] K_SHLEQ  = 6'd34;
   localparam logic [KindBits-1:0] K_SHR    = 6'd35;
   localparam logic [KindBits-1:0] K_SHREQ  = 6'd36;
   localparam logic [KindBits-1:0] K_AMP    = 6'd37;
   localparam logic [KindBits-1:0] K_AMPEQ  = 6'd38;
   localparam logic [KindBits-1:0] K_BAR    = 6'd39;
   localparam logic [KindBits-1:0] K_BAREQ  = 6'd40;
   localparam logic [KindBits-1:0] K_BANG   = 6'd41;
   localparam logic [KindBits-1:0] K_NOTEQ  = 6'd42;
   localparam logic [KindBits-1:0] K_LT     = 6'd43;
   localparam logic [KindBits-1:0] K_LE     = 6'd44;
   localparam logic [KindBits-1:0] K_GT     = 6'd45;
   localparam logic [KindBits-1:0] K_GE     = 6'd46;
   localparam logic [KindBits-1:0] K_EQEQ   = 6'd47;
   localparam logic [KindBits-1:0] K_ANDAND = 6'd48;
   localparam logic [KindBits-1:0] K_ANDANDEQ = 6'd49;
   localparam logic [KindBits-1:0] K_OROR   = 6'd50;
   localparam logic [KindBits-1:0] K_ORbusEQ = 6'd51;
   localparam logic [KindBits-1:0] K_LBRACE = 6'd52;
   localparam logic [KindBits-1:0] K_RBRACE = 6'd53;
   localparam logic [KindBits-1:0] K_LBRACK = 6'd54;
   localparam logic [KindBits-1:0] K_RBRACK = 6'd55;
   localparam logic [KindBits-1:0] K_LPAREN = 6'd56;
   localparam logic [KindBits-1:0] K_RPAREN = 6'd57;
   localparam logic [KindBits-1:0] K_SEMI   = 6'd58;
   localparam logic [KindBits-1:0] K_COLON  = 6'd59;
   localparam logic [KindBits-1:0] K_DOT    = 6'd60;
   localparam logic [KindBits-1:0] K_COMMA  = 6'd61;
   localparam logic [KindBits-1:0] K_CARET  = 6'd62;
   localparam logic [KindBits-1:0] K_END    = 6'd63;

   // Raw request (text byte and end flag) passed from the front to the back.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic is_num(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

FILE: design/stl_front.sv
// Input side: a two-entry queue that decouples request acceptance from the scanner.
module stl_front import stl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output req_type out_data
);

   req_type     slot_ff [2];
   req_type     slot_in [2];
   logic [1:0]  count_ff, count_in;
   logic        rd_ff, rd_in, wr_ff, wr_in;
   logic        push, pop;

   assign in_ready  = count_ff != 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill updates.
   always_comb begin
      slot_in  = slot_ff;
      count_in = count_ff;
      rd_in    = rd_ff;
      wr_in    = wr_ff;
      if (push) begin
         slot_in[wr_ff] = in_data;
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff    <= 1'b0;
         wr_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff    <= rd_in;
         wr_ff    <= wr_in;
      end
   end

endmodule

FILE: design/stl_back.sv
// Scanner: one request per cycle unless the token queue stalls it; emits up to two tokens.
`include "source_token_lexer_macros.svh"
module stl_back import stl_pkg::*; #(
   parameter int KEYWORD_BYTES = KeywordBytesDefault,
   parameter int LENGTH_BITS   = LengthBitsDefault,
   parameter int LINE_BITS     = LineBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  req_type                in_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [KindBits-1:0]    rsp_kind,
   output logic [LINE_BITS-1:0]   rsp_line,
   output logic [ColumnBits-1:0]  rsp_col,
   output logic [LENGTH_BITS-1:0] rsp_raw,
   output logic [LENGTH_BITS-1:0] rsp_esc,
   output logic                   rsp_frac,
   output logic                   rsp_last
);

   localparam logic [LENGTH_BITS-1:0] LenMax  = '1;
   localparam logic [LINE_BITS-1:0]   LineMax = '1;
   localparam logic [ColumnBits-1:0]  ColMax  = '1;

   typedef struct packed {
      logic [KindBits-1:0]    kind;
      logic [LINE_BITS-1:0]   line;
      logic [ColumnBits-1:0]  col;
      logic [LENGTH_BITS-1:0] raw;
      logic [LENGTH_BITS-1:0] esc;
      logic                   frac;
      logic                   last;
   } tok_type;

   // Scanner state.
   logic [ModeBits-1:0]    mode_ff, mode_in;
   logic [7:0]             kbuf_ff [KEYWORD_BYTES];
   logic [7:0]             kbuf_in [KEYWORD_BYTES];
   logic [LENGTH_BITS-1:0] tlen_ff, tlen_in, elen_ff, elen_in;
   logic                   escp_ff, escp_in, frac_ff, frac_in;
   logic [LINE_BITS-1:0]   line_ff, line_in, sline_ff, sline_in;
   logic [ColumnBits-1:0]  col_ff, col_in, scol_ff, scol_in;

   // Output queue of four tokens.
   tok_type     q_ff [4];
   tok_type     q_in [4];
   logic [2:0]  qcnt_ff, qcnt_in;
   logic [1:0]  qrd_ff, qrd_in, qwr_ff;
   logic [1:0]  qwr_in;

   tok_type     t0, t1;
   logic        e0, e1;
   logic        fire;

   function automatic logic [LENGTH_BITS-1:0] inc_len(input logic [LENGTH_BITS-1:0] v);
      return (v == LenMax) ? v : v + 1'b1;
   endfunction

   function automatic logic [LINE_BITS-1:0] inc_line(input logic [LINE_BITS-1:0] v);
      return (v == LineMax) ? v : v + 1'b1;
   endfunction

   function automatic logic [ColumnBits-1:0] inc_col(input logic [ColumnBits-1:0] v);
      return (v == ColMax) ? v : v + 1'b1;
   endfunction

   // Compares the word buffer with a fixed word of up to eight letters.
   function automatic logic word_eq(input logic [7:0] buf_w [KEYWORD_BYTES],
                                    input logic [63:0] w, input int n);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i < n && buf_w[i] != w[8*(7-i) +: 8]) ok = 1'b0;
      end
      return ok;
   endfunction

   function automatic logic [KindBits-1:0] key_kind(input logic [7:0] b [KEYWORD_BYTES],
                                                    input logic [LENGTH_BITS-1:0] n);
      logic [KindBits-1:0] k;
      k = K_IDENT;
      case (n)
         LENGTH_BITS'(2): if (word_eq(b, {"if", 48'd0}, 2)) k = 6'd13;
         LENGTH_BITS'(3): begin
            if (word_eq(b, {"var", 40'd0}, 3)) k = 6'd4;
            if (word_eq(b, {"for", 40'd0}, 3)) k = 6'd15;
         end
         LENGTH_BITS'(4): begin
            if (word_eq(b, {"proc", 32'd0}, 4)) k = 6'd5;
            if (word_eq(b, {"null", 32'd0}, 4)) k = 6'd8;
            if (word_eq(b, {"true", 32'd0}, 4)) k = 6'd9;
            if (word_eq(b, {"else", 32'd0}, 4)) k = 6'd14;
            if (word_eq(b, {"cast", 32'd0}, 4)) k = 6'd19;
         end
         LENGTH_BITS'(5): begin
            if (word_eq(b, {"false", 24'd0}, 5)) k = 6'd10;
            if (word_eq(b, {"while", 24'd0}, 5)) k = 6'd16;
            if (word_eq(b, {"break", 24'd0}, 5)) k = 6'd17;
         end
         LENGTH_BITS'(6): begin
            if (word_eq(b, {"struct", 16'd0}, 6)) k = 6'd6;
            if (word_eq(b, {"return", 16'd0}, 6)) k = 6'd7;
            if (word_eq(b, {"sizeof", 16'd0}, 6)) k = 6'd11;
            if (word_eq(b, {"typeof", 16'd0}, 6)) k = 6'd12;
         end
         LENGTH_BITS'(8): if (word_eq(b, "continue", 8)) k = 6'd18;
         default: k = K_IDENT;
      endcase
      return k;
   endfunction

   function automatic logic [KindBits-1:0] dir_kind(input logic [7:0] b [KEYWORD_BYTES],
                                                    input logic [LENGTH_BITS-1:0] n);
      logic [KindBits-1:0] k;
      k = K_ERROR;
      case (n)
         LENGTH_BITS'(5): if (word_eq(b, {"print", 24'd0}, 5)) k = 6'd20;
         LENGTH_BITS'(6): begin
            if (word_eq(b, {"assert", 16'd0}, 6)) k = 6'd21;
            if (word_eq(b, {"c_code", 16'd0}, 6)) k = 6'd23;
         end
         LENGTH_BITS'(7): if (word_eq(b, {"foreign", 8'd0}, 7)) k = 6'd22;
         default: k = K_ERROR;
      endcase
      return k;
   endfunction

   assign in_ready = qcnt_ff <= 3'd2;
   assign fire     = in_valid && in_ready;

   // Scanner next state and token generation.
   always_comb begin
      logic [7:0]          c;
      logic                eot, consumed, got_op;
      logic [KindBits-1:0] op_a, op_e;
      logic [7:0]          pk;
      c        = in_data.text_byte;
      eot      = in_data.end_of_text || c == 8'd0;
      mode_in  = mode_ff;
      kbuf_in  = kbuf_ff;
      tlen_in  = tlen_ff;
      elen_in  = elen_ff;
      escp_in  = escp_ff;
      frac_in  = frac_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      sline_in = sline_ff;
      scol_in  = scol_ff;
      e0 = 1'b0;
      e1 = 1'b0;
      t0 = '0;
      t1 = '0;
      consumed = 1'b0;
      got_op = 1'b0;
      op_a = K_ERROR;
      op_e = K_ERROR;
      pk = 8'd0;
      t0.line = sline_ff;
      t0.col  = scol_ff;
      t0.raw  = tlen_ff;

      // Pending token in progress.
      case (mode_ff)
         M_IDENT: begin
            if (!eot && (is_alpha(c) || is_num(c))) begin
               for (int i = 0; i < KEYWORD_BYTES; i++)
                  if (tlen_ff == LENGTH_BITS'(i)) kbuf_in[i] = c;
               tlen_in = inc_len(tlen_ff);
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end else begin
               e0 = 1'b1;
               t0.kind = key_kind(kbuf_ff, tlen_ff);
            end
         end
         M_ZERO, M_INT, M_FRAC: begin
            if (!eot && mode_ff != M_ZERO && is_num(c)) begin
               tlen_in = inc_len(tlen_ff);
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end else if (!eot && mode_ff != M_FRAC && c == 8'h2e) begin
               frac_in = 1'b1;
               mode_in = M_FRAC;
               tlen_in = inc_len(tlen_ff);
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end else begin
               e0 = 1'b1;
               t0.kind = K_NUMBER;
               t0.frac = frac_ff;
            end
         end
         M_STR, M_STRBAD: begin
            if (eot) begin
               e0 = 1'b1;
               t0.kind = K_ERROR;
            end else begin
               consumed = 1'b1;
               if (c == 8'h0a) line_in = inc_line(line_ff);
               col_in = inc_col(col_ff);
               if (escp_ff) begin
                  escp_in = 1'b0;
                  if (!(c == 8'h22 || c == 8'h5c || c == 8'h62 || c == 8'h66 ||
                        c == 8'h6e || c == 8'h72 || c == 8'h74))
                     mode_in = M_STRBAD;
                  tlen_in = inc_len(tlen_ff);
                  elen_in = inc_len(elen_ff);
               end else if (c == 8'h22) begin
                  e0 = 1'b1;
                  if (mode_ff == M_STR) begin
                     t0.kind = K_STRING;
                     t0.esc = elen_ff;
                  end else begin
                     t0.kind = K_ERROR;
                  end
                  mode_in = M_IDLE;
               end else if (c == 8'h5c) begin
                  escp_in = 1'b1;
                  tlen_in = inc_len(tlen_ff);
               end else begin
                  tlen_in = inc_len(tlen_ff);
                  elen_in = inc_len(elen_ff);
               end
            end
         end
         M_SLASH: begin
            if (!eot && c == 8'h2f) begin
               mode_in = M_COMMENT;
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end else begin
               got_op = 1'b1;
               op_a = K_SLASH;
               op_e = K_SLASHEQ;
            end
         end
         M_COMMENT: begin
            if (!eot && c != 8'h0a) begin
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end
         end
         M_PLUS:  begin got_op = 1'b1; op_a = K_PLUS;   op_e = K_PLUSEQ;   end
         M_MINUS: begin got_op = 1'b1; op_a = K_MINUS;  op_e = K_MINEQ;    end
         M_STAR:  begin got_op = 1'b1; op_a = K_STAR;   op_e = K_STAREQ;   end
         M_EQ:    begin got_op = 1'b1; op_a = K_ASSIGN; op_e = K_EQEQ;     end
         M_BANG:  begin got_op = 1'b1; op_a = K_BANG;   op_e = K_NOTEQ;    end
         M_LT2:   begin got_op = 1'b1; op_a = K_SHL;    op_e = K_SHLEQ;    end
         M_GT2:   begin got_op = 1'b1; op_a = K_SHR;    op_e = K_SHREQ;    end
         M_AMP2:  begin got_op = 1'b1; op_a = K_ANDAND; op_e = K_ANDANDEQ; end
         M_BAR2:  begin got_op = 1'b1; op_a = K_OROR;   op_e = K_ORbusEQ;  end
         M_LT, M_GT, M_AMP, M_BAR: begin
            case (mode_ff)
               M_LT:    begin pk = 8'h3c; op_a = K_LT;  op_e = K_LE;    end
               M_GT:    begin pk = 8'h3e; op_a = K_GT;  op_e = K_GE;    end
               M_AMP:   begin pk = 8'h26; op_a = K_AMP; op_e = K_AMPEQ; end
               default: begin pk = 8'h7c; op_a = K_BAR; op_e = K_BAREQ; end
            endcase
            if (!eot && c == pk) begin
               tlen_in = inc_len(tlen_ff);
               mode_in = mode_ff + 5'd1;
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end else begin
               got_op = 1'b1;
            end
         end
         M_HASH: begin
            if (!eot && is_alpha(c)) begin
               kbuf_in[0] = c;
               tlen_in = inc_len(tlen_ff);
               mode_in = M_DIRECT;
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end else begin
               e0 = 1'b1;
               t0.kind = K_ERROR;
            end
         end
         M_DIRECT: begin
            if (!eot && (is_alpha(c) || is_num(c))) begin
               for (int i = 0; i < KEYWORD_BYTES; i++)
                  if (tlen_ff - 1'b1 == LENGTH_BITS'(i)) kbuf_in[i] = c;
               tlen_in = inc_len(tlen_ff);
               col_in = inc_col(col_ff);
               consumed = 1'b1;
            end else begin
               e0 = 1'b1;
               t0.kind = dir_kind(kbuf_ff, tlen_ff - 1'b1);
            end
         end
         default: consumed = 1'b0;
      endcase

      // Operator that may take a trailing '='; either way the operator is finished.
      if (got_op) begin
         e0 = 1'b1;
         if (!eot && c == 8'h3d) begin
            t0.kind = op_e;
            t0.raw = inc_len(tlen_ff);
            col_in = inc_col(col_ff);
            mode_in = M_IDLE;
            consumed = 1'b1;
         end else begin
            t0.kind = op_a;
         end
      end
      if (!consumed && mode_ff != M_STR && mode_ff != M_STRBAD) mode_in = M_IDLE;

      if (eot) begin
         // Pending token already flushed above; now the end token and a full reset.
         e1 = 1'b1;
         t1.kind = K_END;
         t1.line = line_ff;
         t1.col = col_ff;
         mode_in = M_IDLE;
         for (int i = 0; i < KEYWORD_BYTES; i++) kbuf_in[i] = 8'd0;
         tlen_in = '0;
         elen_in = '0;
         escp_in = 1'b0;
         frac_in = 1'b0;
         line_in = LINE_BITS'(1);
         col_in = ColumnBits'(1);
         sline_in = '0;
         scol_in = '0;
      end else if (!consumed) begin
         // Byte starts a new token.
         sline_in = line_ff;
         scol_in = col_ff;
         tlen_in = LENGTH_BITS'(1);
         elen_in = '0;
         escp_in = 1'b0;
         frac_in = 1'b0;
         t1.line = line_ff;
         t1.col = col_ff;
         t1.raw = LENGTH_BITS'(1);
         col_in = inc_col(col_ff);
         if (c == 8'h0a) begin
            line_in = inc_line(line_ff);
            col_in = ColumnBits'(1);
         end else if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == 8'h0b) begin
            col_in = inc_col(col_ff);
         end else if (is_alpha(c)) begin
            kbuf_in[0] = c;
            mode_in = M_IDENT;
         end else if (c == 8'h30) begin
            mode_in = M_ZERO;
         end else if (is_num(c)) begin
            mode_in = M_INT;
         end else begin
            e1 = 1'b1;
            case (c)
               8'h22: begin mode_in = M_STR; tlen_in = '0; e1 = 1'b0; end
               8'h2f: begin mode_in = M_SLASH; e1 = 1'b0; end
               8'h2b: begin mode_in = M_PLUS;  e1 = 1'b0; end
               8'h2d: begin mode_in = M_MINUS; e1 = 1'b0; end
               8'h2a: begin mode_in = M_STAR;  e1 = 1'b0; end
               8'h3d: begin mode_in = M_EQ;    e1 = 1'b0; end
               8'h21: begin mode_in = M_BANG;  e1 = 1'b0; end
               8'h3c: begin mode_in = M_LT;    e1 = 1'b0; end
               8'h3e: begin mode_in = M_GT;    e1 = 1'b0; end
               8'h26: begin mode_in = M_AMP;   e1 = 1'b0; end
               8'h7c: begin mode_in = M_BAR;   e1 = 1'b0; end
               8'h23: begin mode_in = M_HASH;  e1 = 1'b0; end
               8'h7b: t1.kind = K_LBRACE;
               8'h7d: t1.kind = K_RBRACE;
               8'h5b: t1.kind = K_LBRACK;
               8'h5d: t1.kind = K_RBRACK;
               8'h28: t1.kind = K_LPAREN;
               8'h29: t1.kind = K_RPAREN;
               8'h3b: t1.kind = K_SEMI;
               8'h3a: t1.kind = K_COLON;
               8'h2e: t1.kind = K_DOT;
               8'h2c: t1.kind = K_COMMA;
               8'h5e: t1.kind = K_CARET;
               default: t1.kind = K_ERROR;
            endcase
         end
      end
      t0.last = !e1;
      t1.last = 1'b1;
   end

   // Output queue: up to two pushes and one pop a cycle.
   always_comb begin
      logic [2:0] n;
      logic [1:0] w;
      q_in = q_ff;
      w = qwr_ff;
      n = 3'd0;
      if (fire && e0) begin
         q_in[w] = t0;
         w = w + 2'd1;
         n = n + 3'd1;
      end
      if (fire && e1) begin
         q_in[w] = t1;
         w = w + 2'd1;
         n = n + 3'd1;
      end
      qwr_in = w;
      qrd_in = (rsp_tvalid && rsp_tready) ? qrd_ff + 2'd1 : qrd_ff;
      qcnt_in = qcnt_ff + n - ((rsp_tvalid && rsp_tready) ? 3'd1 : 3'd0);
   end

   assign rsp_tvalid = qcnt_ff != 3'd0;
   assign rsp_kind   = q_ff[qrd_ff].kind;
   assign rsp_line   = q_ff[qrd_ff].line;
   assign rsp_col    = q_ff[qrd_ff].col;
   assign rsp_raw    = q_ff[qrd_ff].raw;
   assign rsp_esc    = q_ff[qrd_ff].esc;
   assign rsp_frac   = q_ff[qrd_ff].frac;
   assign rsp_last   = q_ff[qrd_ff].last;

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         qcnt_ff  <= 3'd0;
         qrd_ff   <= 2'd0;
         qwr_ff   <= 2'd0;
         mode_ff  <= M_IDLE;
         for (int i = 0; i < KEYWORD_BYTES; i++) kbuf_ff[i] <= 8'd0;
         tlen_ff  <= '0;
         elen_ff  <= '0;
         escp_ff  <= 1'b0;
         frac_ff  <= 1'b0;
         line_ff  <= LINE_BITS'(1);
         col_ff   <= ColumnBits'(1);
         sline_ff <= '0;
         scol_ff  <= '0;
      end else begin
         qcnt_ff <= qcnt_in;
         qrd_ff  <= qrd_in;
         qwr_ff  <= qwr_in;
         if (fire) begin
            mode_ff  <= mode_in;
            kbuf_ff  <= kbuf_in;
            tlen_ff  <= tlen_in;
            elen_ff  <= elen_in;
            escp_ff  <= escp_in;
            frac_ff  <= frac_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            sline_ff <= sline_in;
            scol_ff  <= scol_in;
         end
      end
   end

   `STL_ASSERT(a_qcnt_bound, clock, reset, qcnt_ff <= 3'd4, "token queue overflow")
   `STL_ASSERT(a_no_accept_full, clock, reset, qcnt_ff > 3'd2 |-> !in_ready, "accept when full")
   `STL_ASSERT(a_line_nonzero, clock, reset, line_ff != '0, "line counter reached zero")
   `STL_ASSERT(a_end_resets, clock, reset,
      fire && e1 && t1.kind == K_END |=> mode_ff == M_IDLE, "end token left scanner busy")

endmodule

FILE: design/source_token_lexer.sv
// Requests pass through the input queue and the scanner; tokens are registered in the token queue.
// Throughput: one source byte per cycle unless stalled; each byte yields at most two tokens,
// drained one a cycle while rsp_tready is high. The input stalls when the four-entry token queue
// cannot take two more tokens and the two-entry input queue has filled behind it.
// Reset: synchronous, active high; scanner returns to idle at line 1, column 1, queues empty.
module source_token_lexer import stl_pkg::*; #(
   parameter int KEYWORD_BYTES = KeywordBytesDefault,
   parameter int LENGTH_BITS   = LengthBitsDefault,
   parameter int LINE_BITS     = LineBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // text_byte
   input  logic                   req_tlast,   // end_of_text
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // kind, start line, start column, raw length, unescaped length, fraction flag, zero padding
   output logic [((KindBits+LINE_BITS+ColumnBits+2*LENGTH_BITS+1+7)/8)*8-1:0] rsp_tdata,
   output logic                   rsp_tlast    // last_of_run
);

   localparam int FieldBits = KindBits + LINE_BITS + ColumnBits + 2 * LENGTH_BITS + 1;
   localparam int DataBits  = ((FieldBits + 7) / 8) * 8;

   req_type                q_data, in_req;
   logic                   q_valid, q_ready;
   logic [KindBits-1:0]    kind;
   logic [LINE_BITS-1:0]   line;
   logic [ColumnBits-1:0]  col;
   logic [LENGTH_BITS-1:0] raw, esc;
   logic                   frac;

   assign in_req.text_byte   = req_tdata;
   assign in_req.end_of_text = req_tlast;

   stl_front u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(in_req),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   stl_back #(
      .KEYWORD_BYTES(KEYWORD_BYTES), .LENGTH_BITS(LENGTH_BITS), .LINE_BITS(LINE_BITS)
   ) u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .rsp_tvalid, .rsp_tready,
      .rsp_kind(kind), .rsp_line(line), .rsp_col(col),
      .rsp_raw(raw), .rsp_esc(esc), .rsp_frac(frac), .rsp_last(rsp_tlast)
   );

   // Fields packed from the lowest bit up, padded with zeros to whole bytes.
   assign rsp_tdata = DataBits'({frac, esc, raw, col, line, kind});

endmodule

FILE: tb/source_token_lexer_tb.sv
module source_token_lexer_tb;
   import stl_pkg::*;

   localparam int FieldBits = KindBits + LineBitsDefault + ColumnBits + 2*LengthBitsDefault + 1;
   localparam int DataBits  = ((FieldBits + 7) / 8) * 8;
   localparam int LenMax    = 16'hFFFF;
   localparam int LineMax   = 20'hFFFFF;

   // Field order in rsp_tdata, lowest bits first: kind, line, column, raw, escaped, fraction.
   typedef struct packed {
      logic [5:0]  kind;
      logic [19:0] line;
      logic [15:0] col;
      logic [15:0] raw;
      logic [15:0] esc;
      logic        frac;
      logic        last;
   } token_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [7:0]          req_tdata;   // text_byte
   logic                req_tlast;   // end_of_text
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [DataBits-1:0] rsp_tdata;   // kind, line, column, raw, escaped, fraction, padding
   logic                rsp_tlast;   // last_of_run

   source_token_lexer dut (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Predicted scanner state.
   logic [4:0]  sc_mode;
   logic [7:0]  sc_word [8];
   int unsigned sc_len, sc_esc, sc_line, sc_col, sc_tline, sc_tcol;
   bit          sc_escp, sc_frac;
   token_type   tokens_due [$];
   token_type   step_out [$];
   int          errors = 0;
   int          hold_off;
   int          hold_req;
   int          hold_seen;
   bit          burst_mode;

   function automatic int unsigned sat_inc(int unsigned v, int unsigned m);
      return (v < m) ? v + 1 : m;
   endfunction

   function automatic bit alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function void scanner_clear();
      sc_mode = M_IDLE;
      foreach (sc_word[i]) sc_word[i] = 8'd0;
      sc_len = 0; sc_esc = 0; sc_escp = 0; sc_frac = 0;
      sc_line = 1; sc_col = 1; sc_tline = 0; sc_tcol = 0;
   endfunction

   function void add_token(int unsigned kind, int unsigned raw, int unsigned esc, bit frac);
      token_type t;
      if (step_out.size() >= 2) return;
      t.kind = kind[5:0]; t.line = sc_tline[19:0]; t.col = sc_tcol[15:0];
      t.raw = raw[15:0]; t.esc = esc[15:0]; t.frac = frac; t.last = 1'b0;
      step_out.push_back(t);
   endfunction

   function automatic bit word_is(string s, int unsigned n);
      if (n != s.len() || n > 8) return 0;
      for (int i = 0; i < n; i++)
         if (sc_word[i] != s[i]) return 0;
      return 1;
   endfunction

   // Keyword table: identifiers that match give their own kind.
   function automatic int unsigned keyword_kind(int unsigned n);
      string words [16] = '{"var", "proc", "struct", "return", "null", "true", "false",
                            "sizeof", "typeof", "if", "else", "for", "while", "break",
                            "continue", "cast"};
      for (int i = 0; i < 16; i++)
         if (word_is(words[i], n)) return 4 + i;
      return K_IDENT;
   endfunction

   function automatic int unsigned directive_kind(int unsigned n);
      string words [4] = '{"print", "assert", "foreign", "c_code"};
      for (int i = 0; i < 4; i++)
         if (word_is(words[i], n)) return 20 + i;
      return K_ERROR;
   endfunction

   function void put_word(int unsigned pos, logic [7:0] c);
      if (pos < 8) sc_word[pos] = c;
   endfunction

   function automatic bit op_end(logic [7:0] c, int unsigned alone, int unsigned with_eq);
      sc_mode = M_IDLE;
      if (c == "=") begin
         add_token(with_eq, sat_inc(sc_len, LenMax), 0, 0);
         sc_col = sat_inc(sc_col, 16'hFFFF);
         return 1;
      end
      add_token(alone, sc_len, 0, 0);
      return 0;
   endfunction

   function automatic bit op_pair(logic [7:0] c, logic [7:0] twin, logic [4:0] nxt,
                                  int unsigned alone, int unsigned with_eq);
      if (c == twin) begin
         sc_len = sat_inc(sc_len, LenMax);
         sc_mode = nxt;
         sc_col = sat_inc(sc_col, 16'hFFFF);
         return 1;
      end
      return op_end(c, alone, with_eq);
   endfunction

   // Offers a byte to the token under way; returns 1 when it was absorbed.
   function automatic bit continue_token(logic [7:0] c);
      case (sc_mode)
         M_IDENT: begin
            if (alpha(c) || digit(c)) begin
               put_word(sc_len, c);
               sc_len = sat_inc(sc_len, LenMax);
               sc_col = sat_inc(sc_col, 16'hFFFF);
               return 1;
            end
            sc_mode = M_IDLE;
            add_token(keyword_kind(sc_len), sc_len, 0, 0);
            return 0;
         end
         M_ZERO, M_INT, M_FRAC: begin
            if ((sc_mode == M_INT || sc_mode == M_FRAC) && digit(c)) begin
               sc_len = sat_inc(sc_len, LenMax);
               sc_col = sat_inc(sc_col, 16'hFFFF);
               return 1;
            end
            if (sc_mode != M_FRAC && c == ".") begin
               sc_frac = 1; sc_mode = M_FRAC;
               sc_len = sat_inc(sc_len, LenMax);
               sc_col = sat_inc(sc_col, 16'hFFFF);
               return 1;
            end
            sc_mode = M_IDLE;
            add_token(K_NUMBER, sc_len, 0, sc_frac);
            return 0;
         end
         M_STR, M_STRBAD: begin
            if (c == 8'h0a) sc_line = sat_inc(sc_line, LineMax);
            sc_col = sat_inc(sc_col, 16'hFFFF);
            if (sc_escp) begin
               sc_escp = 0;
               if (!(c == 8'h22 || c == 8'h5c || c == "b" || c == "f" || c == "n" ||
                     c == "r" || c == "t"))
                  sc_mode = M_STRBAD;
               sc_len = sat_inc(sc_len, LenMax);
               sc_esc = sat_inc(sc_esc, LenMax);
            end else if (c == 8'h22) begin
               if (sc_mode == M_STR) add_token(K_STRING, sc_len, sc_esc, 0);
               else add_token(K_ERROR, sc_len, 0, 0);
               sc_mode = M_IDLE;
            end else if (c == 8'h5c) begin
               sc_escp = 1;
               sc_len = sat_inc(sc_len, LenMax);
            end else begin
               sc_len = sat_inc(sc_len, LenMax);
               sc_esc = sat_inc(sc_esc, LenMax);
            end
            return 1;
         end
         M_SLASH: begin
            if (c == "/") begin
               sc_mode = M_COMMENT;
               sc_col = sat_inc(sc_col, 16'hFFFF);
               return 1;
            end
            return op_end(c, K_SLASH, K_SLASHEQ);
         end
         M_COMMENT: begin
            if (c == 8'h0a) begin
               sc_mode = M_IDLE;
               return 0;
            end
            sc_col = sat_inc(sc_col, 16'hFFFF);
            return 1;
         end
         M_PLUS:  return op_end(c, K_PLUS, K_PLUSEQ);
         M_MINUS: return op_end(c, K_MINUS, K_MINEQ);
         M_STAR:  return op_end(c, K_STAR, K_STAREQ);
         M_EQ:    return op_end(c, K_ASSIGN, K_EQEQ);
         M_BANG:  return op_end(c, K_BANG, K_NOTEQ);
         M_LT:    return op_pair(c, "<", M_LT2, K_LT, K_LE);
         M_LT2:   return op_end(c, K_SHL, K_SHLEQ);
         M_GT:    return op_pair(c, ">", M_GT2, K_GT, K_GE);
         M_GT2:   return op_end(c, K_SHR, K_SHREQ);
         M_AMP:   return op_pair(c, "&", M_AMP2, K_AMP, K_AMPEQ);
         M_AMP2:  return op_end(c, K_ANDAND, K_ANDANDEQ);
         M_BAR:   return op_pair(c, "|", M_BAR2, K_BAR, K_BAREQ);
         M_BAR2:  return op_end(c, K_OROR, K_ORbusEQ);
         M_HASH: begin
            if (alpha(c)) begin
               put_word(0, c);
               sc_len = sat_inc(sc_len, LenMax);
               sc_mode = M_DIRECT;
               sc_col = sat_inc(sc_col, 16'hFFFF);
               return 1;
            end
            sc_mode = M_IDLE;
            add_token(K_ERROR, sc_len, 0, 0);
            return 0;
         end
         M_DIRECT: begin
            if (alpha(c) || digit(c)) begin
               put_word(sc_len - 1, c);
               sc_len = sat_inc(sc_len, LenMax);
               sc_col = sat_inc(sc_col, 16'hFFFF);
               return 1;
            end
            sc_mode = M_IDLE;
            add_token(directive_kind(sc_len - 1), sc_len, 0, 0);
            return 0;
         end
         default: begin
            sc_mode = M_IDLE;
            return 0;
         end
      endcase
   endfunction

   // A byte seen between tokens starts a new one.
   function void start_token(logic [7:0] c);
      int unsigned kind;
      kind = 64;
      sc_tline = sc_line; sc_tcol = sc_col;
      sc_len = 1; sc_esc = 0; sc_escp = 0; sc_frac = 0;
      if (c == 8'h0a) begin
         sc_line = sat_inc(sc_line, LineMax);
         sc_col = 1;
         return;
      end
      if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0b) begin
         sc_col = sat_inc(sc_col, 16'hFFFF);
         return;
      end
      if (alpha(c)) begin
         put_word(0, c);
         sc_mode = M_IDENT;
      end else if (c == "0") begin
         sc_mode = M_ZERO;
      end else if (digit(c)) begin
         sc_mode = M_INT;
      end else begin
         case (c)
            8'h22: begin sc_mode = M_STR; sc_len = 0; end
            "/": sc_mode = M_SLASH;
            "+": sc_mode = M_PLUS;
            "-": sc_mode = M_MINUS;
            "*": sc_mode = M_STAR;
            "=": sc_mode = M_EQ;
            "!": sc_mode = M_BANG;
            "<": sc_mode = M_LT;
            ">": sc_mode = M_GT;
            "&": sc_mode = M_AMP;
            "|": sc_mode = M_BAR;
            "#": sc_mode = M_HASH;
            "{": kind = K_LBRACE;
            "}": kind = K_RBRACE;
            "[": kind = K_LBRACK;
            "]": kind = K_RBRACK;
            "(": kind = K_LPAREN;
            ")": kind = K_RPAREN;
            ";": kind = K_SEMI;
            ":": kind = K_COLON;
            ".": kind = K_DOT;
            ",": kind = K_COMMA;
            "^": kind = K_CARET;
            default: kind = K_ERROR;
         endcase
         if (kind != 64) add_token(kind, 1, 0, 0);
      end
      sc_col = sat_inc(sc_col, 16'hFFFF);
   endfunction

   // Works out the tokens that one accepted request gives, and queues them.
   function void predict_tokens(logic [7:0] c, logic eot);
      step_out.delete();
      if (eot || c == 8'd0) begin
         if (sc_mode == M_STR || sc_mode == M_STRBAD)
            add_token(K_ERROR, sc_len, 0, 0);
         else if (sc_mode != M_IDLE && sc_mode != M_COMMENT)
            void'(continue_token(8'd0));
         sc_tline = sc_line; sc_tcol = sc_col;
         add_token(K_END, 0, 0, 0);
         scanner_clear();
      end else if (!continue_token(c)) begin
         start_token(c);
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) tokens_due.push_back(step_out[i]);
   endfunction

   // Sends one request, holding it until accepted, with random gaps between bursts.
   task automatic send_byte(logic [7:0] c, logic eot = 1'b0);
      if (burst_mode && $urandom_range(0, 9) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      if ($urandom_range(0, 20) == 0) burst_mode = !burst_mode;
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eot;
      do @(posedge clock); while (!req_tready);
      predict_tokens(c, eot);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic end_text();
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Compares each token that leaves the block with the oldest one predicted.
   always @(posedge clock) begin
      token_type want;
      token_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         {got.frac, got.esc, got.raw, got.col, got.line, got.kind} = rsp_tdata[FieldBits-1:0];
         got.last = rsp_tlast;
         if (tokens_due.size() == 0) begin
            errors++;
            if (errors <= 10) $display("token mismatch: expected no token, got %p", got);
         end else begin
            want = tokens_due.pop_front();
            if (got != want) begin
               errors++;
               if (errors <= 10)
                  $display("token mismatch: expected %p, got %p", want, got);
            end
         end
      end
   end

   // Receiver stall pattern, with one long hold-off counted here when asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_off   <= 0;
         hold_seen  <= 0;
      end else if (hold_req != hold_seen) begin
         hold_seen  <= hold_req;
         hold_off   <= 200;
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 7) != 0;
      end
   end

   task automatic test_keywords();
      send_text("var proc struct return null true false sizeof typeof if else ");
      send_text("for while break continue cast iffy _x9 Longidentifier ");
      end_text();
   endtask

   task automatic test_operators();
      send_text("= == + += - -= * *= / /= < <= << <<= > >= >> >>= & &= && &&= ");
      send_text("| |= || ||= ! != {}[]();:.,^ a+=b ");
      end_text();
   endtask

   task automatic test_numbers_strings();
      send_text("0 01 1. 12.5 0.25 3.4.5 123abc ");
      send_text("\"hi\\n\\t\\\\\\\"\\b\\f\\r\" \"bad\\q\" \"a\nb\" ");
      send_text("#print #assert #foreign #c_code #bogus # x #1 // note\n@$`~");
      send_text("\"open");
      end_text();
      send_text("abc");
      send_byte(8'd0);
      send_byte(8'hFF); send_byte(8'h80); send_byte(8'h7F);
      end_text();
   endtask

   // Random source text: mostly well-formed pieces, with raw noise bytes mixed in.
   task automatic test_random(int count);
      string pieces [] = '{"var", "x1", "while", "continue", "#print", "#c_code",
                           "\"s\\n\"", "\"q\\z\"", "42", "0.5", "7.", "// c\n", "\n",
                           " ", "\t", "+=", "<<=", ">>", "&&=", "||", "!=", "==",
                           "(", ")", "{", "}", ";", "#zz", "\"a b\"", "cast"};
      int sent;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(1, 255)));
            sent++;
         end else begin
            string p;
            p = pieces[$urandom_range(0, pieces.size()-1)];
            send_text(p);
            sent += p.len();
         end
         if ($urandom_range(0, 60) == 0) begin
            end_text();
            sent++;
         end
      end
      end_text();
   endtask

   task automatic test_backpressure();
      hold_req++;
      send_text("a b c d e f g h i j k l m n o p ( ) ; ");
      end_text();
   endtask

   initial begin
      hold_req = 0;
      burst_mode = 0;
      scanner_clear();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = 8'd0;
      req_tlast = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_keywords();
      test_operators();
      test_numbers_strings();
      test_backpressure();
      test_random(1500);
      req_tvalid <= 1'b0;
      while (tokens_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && tokens_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Run time limit.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
